// ===== sv/ctbs_pkg.sv =====
package ctbs_pkg;

  // Storage is laid out for four sensor channels; NUM_CHANNELS limits which are live.
  localparam int unsigned CH_COUNT     = 4;
  localparam int unsigned NUM_CHANNELS = 4;
  localparam int unsigned FILTER_LEN   = 8;
  localparam int unsigned CH_W         = 2;
  localparam int unsigned DATA_W       = 16;
  localparam int unsigned TICK_W       = 8;
  localparam int unsigned BTN_W        = 3;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned QUEUE_DEPTH  = 2;

  localparam logic [BTN_W-1:0] BTN_NONE = 3'd4;
  localparam logic [7:0]       IDLE_MAX = 8'd255;

  localparam logic CMD_POLL = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_MASK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SENS_0        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SENS_1        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SENS_2        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SENS_3        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_THRESHOLD = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE      = 3'd6;

  typedef struct packed {
    logic              is_read;
    logic [DATA_W-1:0] count;
    logic [TICK_W-1:0] tick;
  } item_t;

  typedef struct packed {
    logic [CH_W-1:0]   polled_channel;
    logic [DATA_W-1:0] filtered;
    logic [DATA_W-1:0] level;
    logic              below;
    logic [BTN_W-1:0]  new_press;
    logic [BTN_W-1:0]  held;
    logic [BTN_W-1:0]  button_read;
  } result_t;

endpackage

// ===== sv/ctbs_queue.sv =====
module ctbs_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           in_cmd,
  input  logic [15:0]    in_count,
  input  logic [7:0]     in_tick,
  output logic           q_valid,
  output ctbs_pkg::item_t q_item,
  input  logic           q_pop
);
  import ctbs_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic             push;
  item_t            in_item;

  assign in_ready = (fill_r != CNT_W'(QUEUE_DEPTH));
  assign q_valid  = (fill_r != '0);
  assign q_item   = mem_r[rd_ptr_r];
  assign push     = in_valid && in_ready;

  // Classify the transaction on entry so the back end sees a decoded kind.
  always_comb begin
    in_item.is_read = (in_cmd == CMD_READ);
    in_item.count   = in_count;
    in_item.tick    = in_tick;
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop && q_valid) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    fill_nxt = fill_r;
    if (push && !(q_pop && q_valid)) begin
      fill_nxt = fill_r + 1'b1;
    end else if (!push && q_pop && q_valid) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

// ===== sv/ctbs_engine.sv =====
module ctbs_engine (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_valid,
  input  ctbs_pkg::item_t                   q_item,
  output logic                              q_pop,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ctbs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ctbs_pkg::DATA_W-1:0]       cfg_data,
  output logic                              res_valid,
  input  logic                              res_ready,
  output ctbs_pkg::result_t                 res
);
  import ctbs_pkg::*;

  // Exact reciprocal for truncating a 16-bit magnitude by FILTER_LEN.
  localparam int unsigned FILTER_SHIFT = DATA_W + $clog2(FILTER_LEN);
  localparam int unsigned FILTER_RECIP =
    ((1 << FILTER_SHIFT) + FILTER_LEN - 1) / FILTER_LEN;
  localparam int unsigned RECIP_W = FILTER_SHIFT + 1;
  localparam int unsigned PROD_W  = DATA_W + RECIP_W;
  localparam logic [CH_COUNT-1:0] LIVE_LIMIT = CH_COUNT'((1 << NUM_CHANNELS) - 1);

  function automatic logic [CH_W-1:0] lowest_enabled(input logic [CH_COUNT-1:0] m);
    logic [CH_W-1:0] r;
    r = '0;
    for (int c = CH_COUNT - 1; c >= 0; c--) begin
      if (m[c]) r = CH_W'(c);
    end
    return r;
  endfunction

  function automatic logic [CH_W-1:0] next_enabled(input logic [CH_W-1:0] from,
                                                   input logic [CH_COUNT-1:0] m);
    logic [CH_W-1:0] r;
    logic            found;
    r     = lowest_enabled(m);
    found = 1'b0;
    for (int c = 0; c < CH_COUNT; c++) begin
      if (!found && (CH_W'(c) > from) && m[c]) begin
        r     = CH_W'(c);
        found = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic logic [CH_COUNT-1:0] live_of(input logic [CH_COUNT-1:0] mask);
    logic [CH_COUNT-1:0] m;
    m = mask & LIVE_LIMIT;
    return (m == '0) ? CH_COUNT'(1) : m;
  endfunction

  // Configuration registers.
  logic [CH_COUNT-1:0] mask_r, mask_nxt;
  logic [7:0]          sens_r [CH_COUNT];
  logic [7:0]          sens_nxt [CH_COUNT];
  logic [DATA_W-1:0]   min_thr_r, min_thr_nxt;
  logic [7:0]          debounce_r, debounce_nxt;

  // Scanner state.
  logic [CH_W-1:0]     cur_ch_r, cur_ch_nxt;
  logic [DATA_W-1:0]   avg_r [CH_COUNT];
  logic [DATA_W-1:0]   avg_nxt [CH_COUNT];
  logic [DATA_W-1:0]   base_r [CH_COUNT];
  logic [DATA_W-1:0]   base_nxt [CH_COUNT];
  logic [DATA_W-1:0]   bin_r [CH_COUNT][2];
  logic [DATA_W-1:0]   bin_nxt [CH_COUNT][2];
  logic                act_bin_r, act_bin_nxt;
  logic [TICK_W-1:0]   last_tick_r, last_tick_nxt;
  logic [7:0]          idle_r, idle_nxt;
  logic [BTN_W-1:0]    holding_r, holding_nxt;
  logic [BTN_W-1:0]    latched_r, latched_nxt;

  logic                res_valid_r, res_valid_nxt;
  result_t             res_r, res_nxt;

  // Poll datapath.
  logic [CH_W-1:0]     ch;
  logic [CH_COUNT-1:0] live;
  logic [DATA_W-1:0]   lvl;
  logic [DATA_W-1:0]   sens_ch;
  logic [DATA_W-1:0]   thr;
  logic [DATA_W:0]     diff;
  logic [DATA_W-1:0]   mag;
  logic [PROD_W-1:0]   prod;
  logic [DATA_W-1:0]   quo;
  logic [DATA_W-1:0]   filt;
  logic                below;
  logic [DATA_W-1:0]   lvl_less;

  assign cfg_ready = 1'b1;
  assign q_pop     = q_valid && (!res_valid_r || res_ready);
  assign res_valid = res_valid_r;
  assign res       = res_r;

  assign ch       = cur_ch_r;
  assign live     = live_of(mask_r);
  assign lvl      = base_r[ch];
  assign sens_ch  = DATA_W'(sens_r[ch]);
  assign lvl_less = lvl - sens_ch;
  assign thr      = ((lvl > sens_ch) && (lvl_less >= min_thr_r)) ? lvl_less : min_thr_r;
  assign diff     = {1'b0, q_item.count} - {1'b0, avg_r[ch]};
  assign mag      = diff[DATA_W] ? DATA_W'(-diff) : diff[DATA_W-1:0];
  assign prod     = PROD_W'(mag) * PROD_W'(FILTER_RECIP);
  assign quo      = prod[FILTER_SHIFT +: DATA_W];
  assign filt     = diff[DATA_W] ? avg_r[ch] - quo : avg_r[ch] + quo;
  assign below    = (filt < thr);

  always_comb begin
    logic [DATA_W-1:0] bin_upd [CH_COUNT][2];
    logic              new_bin;
    logic [BTN_W-1:0]  press;

    mask_nxt      = mask_r;
    sens_nxt      = sens_r;
    min_thr_nxt   = min_thr_r;
    debounce_nxt  = debounce_r;
    cur_ch_nxt    = cur_ch_r;
    avg_nxt       = avg_r;
    base_nxt      = base_r;
    bin_nxt       = bin_r;
    act_bin_nxt   = act_bin_r;
    last_tick_nxt = last_tick_r;
    idle_nxt      = idle_r;
    holding_nxt   = holding_r;
    latched_nxt   = latched_r;
    res_nxt       = res_r;
    bin_upd       = bin_r;
    new_bin       = ~act_bin_r;
    press         = BTN_NONE;

    if (q_pop) begin
      if (q_item.is_read) begin
        res_nxt.polled_channel = '0;
        res_nxt.filtered       = '0;
        res_nxt.level          = '0;
        res_nxt.below          = 1'b0;
        res_nxt.new_press      = BTN_NONE;
        res_nxt.held           = holding_r;
        res_nxt.button_read    = latched_r;
        latched_nxt            = BTN_NONE;
      end else begin
        avg_nxt[ch] = filt;

        if (below) begin
          if (latched_r == BTN_NONE && holding_r == BTN_NONE && idle_r > debounce_r) begin
            latched_nxt = BTN_W'(ch);
            holding_nxt = BTN_W'(ch);
            idle_nxt    = '0;
            press       = BTN_W'(ch);
          end
        end else begin
          if (holding_r == BTN_W'(ch)) begin
            holding_nxt = BTN_NONE;
          end
          if ((holding_r == BTN_W'(ch) || holding_r == BTN_NONE) && idle_r < IDLE_MAX) begin
            idle_nxt = idle_r + 1'b1;
          end
        end

        if (filt > bin_r[ch][act_bin_r]) begin
          bin_upd[ch][act_bin_r] = filt;
        end
        bin_nxt = bin_upd;

        // A tick change flips the bins: baseline takes the max of both,
        // and the newly active bin restarts from the current average.
        if (q_item.tick != last_tick_r) begin
          act_bin_nxt   = new_bin;
          last_tick_nxt = q_item.tick;
          for (int c = 0; c < CH_COUNT; c++) begin
            if (live[c]) begin
              base_nxt[c] = (bin_upd[c][0] > bin_upd[c][1]) ? bin_upd[c][0] : bin_upd[c][1];
              bin_nxt[c][new_bin] = avg_nxt[c];
            end
          end
        end

        cur_ch_nxt = next_enabled(ch, live);

        res_nxt.polled_channel = ch;
        res_nxt.filtered       = filt;
        res_nxt.level          = lvl;
        res_nxt.below          = below;
        res_nxt.new_press      = press;
        res_nxt.held           = holding_nxt;
        res_nxt.button_read    = BTN_NONE;
      end
    end

    if (cfg_valid) begin
      unique case (cfg_index)
        REG_CHANNEL_MASK: begin
          mask_nxt   = cfg_data[CH_COUNT-1:0];
          cur_ch_nxt = lowest_enabled(live_of(cfg_data[CH_COUNT-1:0]));
        end
        REG_SENS_0:        sens_nxt[0]  = cfg_data[7:0];
        REG_SENS_1:        sens_nxt[1]  = cfg_data[7:0];
        REG_SENS_2:        sens_nxt[2]  = cfg_data[7:0];
        REG_SENS_3:        sens_nxt[3]  = cfg_data[7:0];
        REG_MIN_THRESHOLD: min_thr_nxt  = cfg_data;
        REG_DEBOUNCE:      debounce_nxt = cfg_data[7:0];
        default: ;
      endcase
    end

    if (q_pop) begin
      res_valid_nxt = 1'b1;
    end else if (res_ready) begin
      res_valid_nxt = 1'b0;
    end else begin
      res_valid_nxt = res_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '1;
      min_thr_r   <= DATA_W'(16);
      debounce_r  <= 8'd10;
      cur_ch_r    <= lowest_enabled(live_of('1));
      act_bin_r   <= 1'b0;
      last_tick_r <= '0;
      idle_r      <= IDLE_MAX;
      holding_r   <= BTN_NONE;
      latched_r   <= BTN_NONE;
      res_valid_r <= 1'b0;
      for (int c = 0; c < CH_COUNT; c++) begin
        sens_r[c]    <= '0;
        avg_r[c]     <= '0;
        base_r[c]    <= '0;
        bin_r[c][0]  <= '0;
        bin_r[c][1]  <= '0;
      end
    end else begin
      mask_r      <= mask_nxt;
      min_thr_r   <= min_thr_nxt;
      debounce_r  <= debounce_nxt;
      cur_ch_r    <= cur_ch_nxt;
      act_bin_r   <= act_bin_nxt;
      last_tick_r <= last_tick_nxt;
      idle_r      <= idle_nxt;
      holding_r   <= holding_nxt;
      latched_r   <= latched_nxt;
      res_valid_r <= res_valid_nxt;
      sens_r      <= sens_nxt;
      avg_r       <= avg_nxt;
      base_r      <= base_nxt;
      bin_r       <= bin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

endmodule

// ===== sv/cap_touch_button_scanner.sv =====
// Capacitive touch button scanner for up to four sensor channels. Every transaction
// on the input channel yields exactly one result: a poll (cmd 0) filters the count of
// the channel currently being scanned, checks it against that channel's baseline,
// tracks press, hold and debounce, rolls the max bins when the tick changes and then
// moves on to the next enabled channel; a read (cmd 1) returns the latched button and
// clears it. Inputs land in a two-entry queue and the back end updates all state from
// the queue head, so one item is taken per clock in steady state while the output is
// not stalled; each result is registered on the output as its item is taken. The queue
// lets input keep flowing for two items while the output is stalled. Configuration
// is to be written through the cfg port while no item is in flight, which the block
// does not enforce; writing the channel mask restarts the scan at the lowest enabled channel.
module cap_touch_button_scanner (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_cmd,
  input  logic [15:0]                    in_count,
  input  logic [7:0]                     in_tick,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     out_polled_channel,
  output logic [15:0]                    out_filtered,
  output logic [15:0]                    out_level,
  output logic                           out_below,
  output logic [2:0]                     out_new_press,
  output logic [2:0]                     out_held,
  output logic [2:0]                     out_button_read,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ctbs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                    cfg_data
);
  import ctbs_pkg::*;

  logic    q_valid;
  logic    q_pop;
  item_t   q_item;
  result_t res;

  ctbs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_cmd   (in_cmd),
    .in_count (in_count),
    .in_tick  (in_tick),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  ctbs_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res_valid (out_valid),
    .res_ready (out_ready),
    .res       (res)
  );

  assign out_polled_channel = res.polled_channel;
  assign out_filtered       = res.filtered;
  assign out_level          = res.level;
  assign out_below          = res.below;
  assign out_new_press      = res.new_press;
  assign out_held           = res.held;
  assign out_button_read    = res.button_read;

endmodule

// ===== verif/cap_touch_button_scanner_test.sv =====
`timescale 1ns / 1ps

module cap_touch_button_scanner_test;
  import ctbs_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_cmd = CMD_POLL;
  logic [15:0] in_count = '0;
  logic [7:0]  in_tick = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_polled_channel;
  logic [15:0] out_filtered;
  logic [15:0] out_level;
  logic        out_below;
  logic [2:0]  out_new_press;
  logic [2:0]  out_held;
  logic [2:0]  out_button_read;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_CHANNEL_MASK;
  logic [15:0] cfg_data = '0;

  // Scanner state as the block should hold it.
  logic [3:0]       mask_q = 4'hF;
  logic [7:0]       sens_q [4] = '{default: 8'd0};
  logic [15:0]      min_thr_q = 16'd16;
  logic [7:0]       debounce_q = 8'd10;
  logic [1:0]       scan_ch = 2'd0;
  logic [15:0]      avg_q [4] = '{default: 16'd0};
  logic [15:0]      baseline_q [4] = '{default: 16'd0};
  logic [15:0]      bin_max_q [4][2] = '{default: '{default: 16'd0}};
  logic             act_bin = 1'b0;
  logic [7:0]       last_tick = 8'd0;
  logic [7:0]       idle_cnt = IDLE_MAX;
  logic [BTN_W-1:0] held_btn = BTN_NONE;
  logic [BTN_W-1:0] latched_btn = BTN_NONE;

  item_t   pending [$];
  result_t scan_results [$];
  item_t   cur_item;
  result_t want_res;
  int      errors = 0;
  int      gap_left = 0;
  int      burst_left = 0;
  logic [15:0] ready_pat = 16'hFFFF;
  logic [3:0]  pat_pos = 4'd0;

  // Stimulus generator's view of the scan order.
  logic [3:0]  gen_mask = 4'hF;
  logic [1:0]  gen_ch = 2'd0;
  logic [7:0]  gen_tick = 8'd0;
  int          nominal [4];

  cap_touch_button_scanner u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_cmd             (in_cmd),
    .in_count           (in_count),
    .in_tick            (in_tick),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_polled_channel (out_polled_channel),
    .out_filtered       (out_filtered),
    .out_level          (out_level),
    .out_below          (out_below),
    .out_new_press      (out_new_press),
    .out_held           (out_held),
    .out_button_read    (out_button_read),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always #5 clk = ~clk;

  // A mask with no live channel falls back to channel 0 alone.
  function automatic logic [1:0] next_live(logic [1:0] from, logic [3:0] mask);
    logic [3:0] m;
    m = mask & 4'((1 << NUM_CHANNELS) - 1);
    if (m == 4'd0) m = 4'd1;
    for (int c = from + 1; c < 4; c++) if (m[c]) return 2'(c);
    for (int c = 0; c < 4; c++) if (m[c]) return 2'(c);
    return 2'd0;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    case (idx)
      REG_CHANNEL_MASK: begin
        mask_q = val[3:0];
        scan_ch = next_live(2'd3, mask_q);
      end
      REG_SENS_0:        sens_q[0] = val[7:0];
      REG_SENS_1:        sens_q[1] = val[7:0];
      REG_SENS_2:        sens_q[2] = val[7:0];
      REG_SENS_3:        sens_q[3] = val[7:0];
      REG_MIN_THRESHOLD: min_thr_q = val;
      REG_DEBOUNCE:      debounce_q = val[7:0];
      default: ;
    endcase
  endfunction

  function automatic result_t predict_scan(item_t it);
    result_t     r;
    logic [1:0]  ch;
    logic [15:0] thr, filt, lvl;
    logic [3:0]  m;
    int          delta;
    r = '0;
    r.new_press = BTN_NONE;
    r.button_read = BTN_NONE;
    r.held = held_btn;
    if (it.is_read == CMD_READ) begin
      r.button_read = latched_btn;
      latched_btn = BTN_NONE;
      return r;
    end
    ch = scan_ch;
    lvl = baseline_q[ch];
    if (lvl > 16'(sens_q[ch])) begin
      thr = lvl - 16'(sens_q[ch]);
      if (thr < min_thr_q) thr = min_thr_q;
    end else begin
      thr = min_thr_q;
    end
    // Signed division truncates toward zero, as the filter requires.
    delta = (int'(it.count) - int'(avg_q[ch])) / int'(FILTER_LEN);
    filt = 16'(int'(avg_q[ch]) + delta);
    avg_q[ch] = filt;
    if (filt < thr) begin
      r.below = 1'b1;
      if (latched_btn == BTN_NONE && held_btn == BTN_NONE && idle_cnt > debounce_q) begin
        latched_btn = {1'b0, ch};
        held_btn = {1'b0, ch};
        idle_cnt = 8'd0;
        r.new_press = {1'b0, ch};
      end
    end else begin
      if (held_btn == {1'b0, ch}) held_btn = BTN_NONE;
      if (held_btn == BTN_NONE && idle_cnt < IDLE_MAX) idle_cnt++;
    end
    if (filt > bin_max_q[ch][act_bin]) bin_max_q[ch][act_bin] = filt;
    if (it.tick != last_tick) begin
      m = mask_q & 4'((1 << NUM_CHANNELS) - 1);
      if (m == 4'd0) m = 4'd1;
      act_bin = ~act_bin;
      for (int c = 0; c < 4; c++) begin
        if (m[c]) begin
          baseline_q[c] = (bin_max_q[c][0] > bin_max_q[c][1]) ? bin_max_q[c][0] : bin_max_q[c][1];
          bin_max_q[c][act_bin] = avg_q[c];
        end
      end
      last_tick = it.tick;
    end
    scan_ch = next_live(ch, mask_q);
    r.polled_channel = ch;
    r.filtered = filt;
    r.level = lvl;
    r.held = held_btn;
    return r;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // Driver: bursts of transactions separated by random gaps.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) scan_results.push_back(predict_scan(cur_item));
      if (!(in_valid && !in_ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending.size() > 0) begin
          cur_item = pending.pop_front();
          in_valid <= 1'b1;
          in_cmd <= cur_item.is_read;
          in_count <= cur_item.count;
          in_tick <= cur_item.tick;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 23);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: the receiver stalls following a rotating ready pattern redrawn at random.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (scan_results.size() == 0) begin
        $display("%0t: unexpected result, channel %0d filtered %0d", $time,
                 out_polled_channel, out_filtered);
        errors++;
      end else begin
        want_res = scan_results.pop_front();
        check_field("polled_channel", want_res.polled_channel, out_polled_channel);
        check_field("filtered", want_res.filtered, out_filtered);
        check_field("level", want_res.level, out_level);
        check_field("below", want_res.below, out_below);
        check_field("new_press", want_res.new_press, out_new_press);
        check_field("held", want_res.held, out_held);
        check_field("button_read", want_res.button_read, out_button_read);
      end
    end
    if (pat_pos == 4'd15) begin
      ready_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'd1);
    end
    pat_pos <= pat_pos + 4'd1;
    out_ready <= rst_n && ready_pat[pat_pos];
  end

  task automatic add_poll(logic [15:0] count, logic [7:0] tick);
    item_t it;
    it.is_read = CMD_POLL;
    it.count = count;
    it.tick = tick;
    pending.push_back(it);
  endtask

  task automatic add_read();
    item_t it;
    it.is_read = CMD_READ;
    it.count = 16'($urandom);
    it.tick = 8'($urandom);
    pending.push_back(it);
  endtask

  // Wait until every transaction has gone through and the pipeline is empty.
  task automatic settle();
    while (pending.size() != 0 || in_valid || scan_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_regs(logic [3:0] mask, logic [7:0] s0, logic [7:0] s1,
                              logic [7:0] s2, logic [7:0] s3, logic [15:0] thr,
                              logic [7:0] deb);
    logic [15:0] vals [7];
    vals[REG_CHANNEL_MASK] = 16'(mask);
    vals[REG_SENS_0] = 16'(s0);
    vals[REG_SENS_1] = 16'(s1);
    vals[REG_SENS_2] = 16'(s2);
    vals[REG_SENS_3] = 16'(s3);
    vals[REG_MIN_THRESHOLD] = thr;
    vals[REG_DEBOUNCE] = 16'(deb);
    for (int i = 0; i <= int'(REG_DEBOUNCE); i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      apply_reg(CFG_IDX_W'(i), vals[i]);
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
    gen_mask = mask;
    gen_ch = next_live(2'd3, mask);
    for (int c = 0; c < 4; c++) nominal[c] = $urandom_range(3000, 60000);
  endtask

  // Mostly steady readings around a per-channel level, with touches that pull one
  // channel down for a while, occasional reads, wild counts and tick jumps.
  task automatic gen_phase(int n);
    item_t it;
    int    touch_ch, touch_left, touch_drop, lvl;
    touch_ch = 4;
    touch_left = 0;
    touch_drop = 0;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        add_read();
      end else begin
        it.is_read = CMD_POLL;
        if (touch_left == 0 && $urandom_range(0, 19) == 0) begin
          touch_ch = $urandom_range(0, 3);
          touch_left = $urandom_range(16, 60);
          touch_drop = $urandom_range(300, nominal[touch_ch] - 100);
        end
        lvl = nominal[gen_ch] + $urandom_range(0, 100) - 50;
        if (touch_left > 0) begin
          touch_left--;
          if (touch_ch == gen_ch) lvl -= touch_drop;
        end
        it.count = ($urandom_range(0, 11) == 0) ? 16'($urandom) : 16'(lvl);
        if ($urandom_range(0, 5) == 0) gen_tick++;
        if ($urandom_range(0, 24) == 0) gen_tick = 8'($urandom);
        it.tick = gen_tick;
        pending.push_back(it);
        gen_ch = next_live(gen_ch, gen_mask);
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part with reset settings: a read with nothing latched, a press
    // on an empty baseline, held and release, bin changes including tick 255,
    // a press blocked by debounce and one accepted after enough idle polls.
    add_read();
    add_poll(16'h0000, 8'd0);
    add_poll(16'hFFFF, 8'd0);
    add_read();
    add_read();
    add_poll(16'hFFFF, 8'd1);
    add_poll(16'h0001, 8'd1);
    add_poll(16'hFFFF, 8'd2);
    add_poll(16'h8000, 8'd2);
    add_poll(16'h7FFF, 8'd3);
    add_poll(16'h0000, 8'd255);
    for (int i = 0; i < 11; i++) add_poll(16'hFFFF, (i % 2 == 0) ? 8'd255 : 8'd0);
    add_poll(16'h0000, 8'd0);
    add_poll(16'h0000, 8'd0);
    add_read();
    settle();

    program_regs(4'hF, 8'd40, 8'd120, 8'd255, 8'd0, 16'd16, 8'd3);
    gen_phase(170);
    settle();
    program_regs(4'h5, 8'd255, 8'd255, 8'd255, 8'd255, 16'd0, 8'd0);
    gen_phase(170);
    settle();
    // No channel enabled, threshold at its top and a debounce that never clears.
    program_regs(4'h0, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                 16'hFFFF, 8'd255);
    gen_phase(120);
    settle();
    program_regs(4'hA, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                 16'($urandom_range(0, 2000)), 8'd254);
    gen_phase(150);
    settle();
    program_regs(4'($urandom_range(1, 15)), 8'($urandom), 8'($urandom), 8'($urandom),
                 8'($urandom), 16'd16, 8'($urandom_range(0, 20)));
    gen_phase(240);
    settle();
    repeat (10) @(posedge clk);

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/ctbs_pkg.sv
sv/ctbs_queue.sv
sv/ctbs_engine.sv
sv/cap_touch_button_scanner.sv
verif/cap_touch_button_scanner_test.sv
